@@ src/hbp_pkg.sv @@
`timescale 1ns / 1ps

package hbp_pkg;

    localparam int VAL_W      = 32;
    localparam int HEIGHT_W   = 4;
    localparam int MODE_W     = 2;
    localparam int COLUMN_W   = 5;
    localparam int PIXELS_W   = 8;
    localparam int LEVEL_W    = 3;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int PRODUCT_W  = VAL_W + HEIGHT_W;

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 4'd8;

    // plot modes; the unused code behaves as fluct
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUCT = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [MODE_W-1:0]   RESET_MODE       = MODE_NORM;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT     = 4'd5;
    localparam logic [VAL_W-1:0]    RESET_FULL_SCALE = 32'd65535;

    typedef struct packed {
        logic                start;
        logic [VAL_W-1:0]    value;
        logic [VAL_W-1:0]    divisor;
        logic [HEIGHT_W-1:0] height;
    } lvl_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } lvl_rsp_t;

endpackage

@@ src/hbp_level_div.sv @@
`timescale 1ns / 1ps

module hbp_level_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  hbp_pkg::lvl_req_t req,
    output hbp_pkg::lvl_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic [1:0]                          step_reg, step_next;
    logic [hbp_pkg::PRODUCT_W-1:0]       rem_reg, rem_next;
    logic [hbp_pkg::VAL_W-1:0]           div_reg, div_next;
    logic [3:0]                          quo_reg, quo_next;
    logic [hbp_pkg::LEVEL_W-1:0]         hm1_reg, hm1_next;
    logic                                zero_reg, zero_next;
    logic                                done_reg, done_next;
    logic [hbp_pkg::LEVEL_W-1:0]         level_reg, level_next;

    logic [hbp_pkg::VAL_W-1:0]           v_sat;
    logic [hbp_pkg::PRODUCT_W:0]         shifted;
    logic [hbp_pkg::PRODUCT_W:0]         trial;
    logic                                fits;
    logic [3:0]                          quo_step;

    always_comb begin
        v_sat    = (req.value > req.divisor) ? req.divisor : req.value;
        shifted  = (hbp_pkg::PRODUCT_W + 1)'(div_reg) << step_reg;
        trial    = {1'b0, rem_reg} - shifted;
        fits     = !trial[hbp_pkg::PRODUCT_W];
        quo_step = quo_reg | (4'(fits) << step_reg);

        busy_next  = busy_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        hm1_next   = hm1_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        level_next = level_reg;

        if (req.start) begin
            busy_next = 1'b1;
            step_next = 2'd3;
            rem_next  = {{hbp_pkg::HEIGHT_W{1'b0}}, v_sat}
                        * {{hbp_pkg::VAL_W{1'b0}}, req.height};
            div_next  = req.divisor;
            quo_next  = '0;
            hm1_next  = hbp_pkg::LEVEL_W'(req.height - 1'b1);
            zero_next = (req.divisor == '0);
        end else if (busy_reg) begin
            // one restoring step per cycle, quotient never exceeds the height
            if (fits) begin
                rem_next = hbp_pkg::PRODUCT_W'(trial);
            end
            quo_next  = quo_step;
            step_next = step_reg - 1'b1;
            if (step_reg == 2'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg) begin
                    level_next = '0;
                end else if (quo_step > {1'b0, hm1_reg}) begin
                    level_next = hm1_reg;
                end else begin
                    level_next = hbp_pkg::LEVEL_W'(quo_step);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        hm1_reg   <= hm1_next;
        zero_reg  <= zero_next;
        level_reg <= level_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_reg;

endmodule

@@ src/history_bar_plot_renderer_top.sv @@
`timescale 1ns / 1ps
// Samples: one per cycle while idle; a sample without last produces no columns.
// Frame: after the last sample, a min/max scan reads the stored samples, then each
// column steps through read, load, level divider and output, skipping the divider
// when the column is blank.
// Reset: synchronous active low; control, counts, min/max and registers take their
// reset values at once, the sample store is not cleared and needs no pass.

module history_bar_plot_renderer_top #(
    parameter int PLOT_WIDTH  = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [hbp_pkg::VAL_W-1:0]       s_sample,
    input  logic                            s_last,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hbp_pkg::COLUMN_W-1:0]    m_column,
    output logic [hbp_pkg::PIXELS_W-1:0]    m_pixels,
    output logic                            m_frame_end,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbp_pkg::ADDR_W-1:0]      paddr,
    input  logic [hbp_pkg::DATA_W-1:0]      pwdata,
    output logic [hbp_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int SW    = (SAMPLE_BITS < hbp_pkg::VAL_W) ? SAMPLE_BITS : hbp_pkg::VAL_W;
    localparam int IDX_W = (PLOT_WIDTH > 1) ? $clog2(PLOT_WIDTH) : 1;
    localparam int CNT_W = $clog2(PLOT_WIDTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PLOT_WIDTH - 1);
    localparam logic [IDX_W:0]   PW_SUM   = (IDX_W + 1)'(PLOT_WIDTH);
    localparam logic [CNT_W-1:0] PW_CNT   = CNT_W'(PLOT_WIDTH);
    localparam logic [CNT_W:0]   PW_PRES  = (CNT_W + 1)'(PLOT_WIDTH);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_SCAN_END = 7'b0000100,
        ST_COL_RD   = 7'b0001000,
        ST_COL_LD   = 7'b0010000,
        ST_COL_DIV  = 7'b0100000,
        ST_COL_OUT  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                wp_reg, wp_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic [hbp_pkg::VAL_W-1:0]       mn_reg, mn_next;
    logic [hbp_pkg::VAL_W-1:0]       mx_reg, mx_next;
    logic [hbp_pkg::PIXELS_W-1:0]    pix_reg, pix_next;

    logic                            m_valid_reg, m_valid_next;
    logic [hbp_pkg::COLUMN_W-1:0]    column_reg, column_next;
    logic [hbp_pkg::PIXELS_W-1:0]    pixels_reg, pixels_next;
    logic                            frame_end_reg, frame_end_next;

    logic [hbp_pkg::MODE_W-1:0]      mode_reg;
    logic [hbp_pkg::HEIGHT_W-1:0]    height_reg;
    logic [hbp_pkg::VAL_W-1:0]       full_scale_reg;

    logic [SW-1:0]                   mem [PLOT_WIDTH];
    logic [SW-1:0]                   rd_data_reg;
    logic [IDX_W-1:0]                rd_addr;

    logic                            s_accept;
    logic                            m_free;
    logic                            cfg_we;
    logic [IDX_W-1:0]                wp_inc;
    logic [CNT_W-1:0]                count_inc;
    logic [IDX_W:0]                  slot_sum;
    logic [IDX_W-1:0]                slot;
    logic                            present;
    logic                            last_scan;
    logic [hbp_pkg::HEIGHT_W-1:0]    h_eff;
    logic [hbp_pkg::VAL_W-1:0]       data_v;
    logic [hbp_pkg::PIXELS_W:0]      lvl_mask;

    hbp_pkg::lvl_req_t               lvl_req;
    hbp_pkg::lvl_rsp_t               lvl_rsp;

    hbp_level_div u_level_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lvl_req),
        .rsp     (lvl_rsp)
    );

    assign s_accept = s_valid && s_ready;
    assign m_free   = !m_valid_reg || m_ready;
    assign cfg_we   = psel && penable && pwrite;

    always_comb begin
        wp_inc    = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
        count_inc = (count_reg == PW_CNT) ? count_reg : count_reg + 1'b1;
        slot_sum  = {1'b0, wp_reg} + {1'b0, idx_reg};
        slot      = (slot_sum >= PW_SUM) ? IDX_W'(slot_sum - PW_SUM) : IDX_W'(slot_sum);
        // column c shows the sample of age PLOT_WIDTH-1-c
        present   = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(count_reg)) >= PW_PRES;
        last_scan = (CNT_W'(idx_reg) == count_reg - 1'b1);
        rd_addr   = (state_reg == ST_SCAN) ? idx_reg : slot;
        h_eff     = (height_reg > hbp_pkg::MAX_HEIGHT) ? hbp_pkg::MAX_HEIGHT : height_reg;
        data_v    = hbp_pkg::VAL_W'(rd_data_reg);
        lvl_mask  = (hbp_pkg::PIXELS_W + 1)'(1) << (4'(lvl_rsp.level) + 4'd1);

        lvl_req.height = h_eff;
        case (mode_reg)
            hbp_pkg::MODE_RAW: begin
                lvl_req.value   = data_v;
                lvl_req.divisor = full_scale_reg;
            end
            hbp_pkg::MODE_NORM: begin
                lvl_req.value   = data_v;
                lvl_req.divisor = mx_reg;
            end
            default: begin
                lvl_req.value   = data_v - mn_reg;
                lvl_req.divisor = mx_reg - mn_reg;
            end
        endcase
        lvl_req.start = (state_reg == ST_COL_LD) && present && (h_eff != '0);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        idx_next       = idx_reg;
        rd_pend_next   = 1'b0;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        pix_next       = pix_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        column_next    = column_reg;
        pixels_next    = pixels_reg;
        frame_end_next = frame_end_reg;

        // fold the read issued last cycle into the window min/max
        if (rd_pend_reg) begin
            if (data_v < mn_reg) begin
                mn_next = data_v;
            end
            if (data_v > mx_reg) begin
                mx_next = data_v;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    wp_next    = wp_inc;
                    count_next = count_inc;
                    if (s_last) begin
                        mn_next    = '1;
                        mx_next    = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_pend_next = 1'b1;
                if (last_scan) begin
                    state_next = ST_SCAN_END;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_END: begin
                idx_next   = '0;
                state_next = ST_COL_RD;
            end
            ST_COL_RD: begin
                state_next = ST_COL_LD;
            end
            ST_COL_LD: begin
                if (lvl_req.start) begin
                    state_next = ST_COL_DIV;
                end else begin
                    pix_next   = '0;
                    state_next = ST_COL_OUT;
                end
            end
            ST_COL_DIV: begin
                if (lvl_rsp.done) begin
                    pix_next   = hbp_pkg::PIXELS_W'(lvl_mask - 1'b1);
                    state_next = ST_COL_OUT;
                end
            end
            ST_COL_OUT: begin
                if (m_free) begin
                    m_valid_next   = 1'b1;
                    column_next    = hbp_pkg::COLUMN_W'(idx_reg);
                    pixels_next    = pix_reg;
                    frame_end_next = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX) begin
                        // start a fresh history
                        count_next = '0;
                        wp_next    = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_COL_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            wp_reg      <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            mn_reg      <= '1;
            mx_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wp_reg      <= wp_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            mn_reg      <= mn_next;
            mx_reg      <= mx_next;
            m_valid_reg <= m_valid_next;
        end
        pix_reg       <= pix_next;
        column_reg    <= column_next;
        pixels_reg    <= pixels_next;
        frame_end_reg <= frame_end_next;
    end

    // writes happen only in idle; reads run every cycle but are used only outside idle, so no overlap
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem[wp_reg] <= s_sample[SW-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= hbp_pkg::RESET_MODE;
            height_reg     <= hbp_pkg::RESET_HEIGHT;
            full_scale_reg <= hbp_pkg::RESET_FULL_SCALE;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                hbp_pkg::REG_MODE:       mode_reg       <= pwdata[hbp_pkg::MODE_W-1:0];
                hbp_pkg::REG_HEIGHT:     height_reg     <= pwdata[hbp_pkg::HEIGHT_W-1:0];
                hbp_pkg::REG_FULL_SCALE: full_scale_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hbp_pkg::REG_MODE:       prdata = hbp_pkg::DATA_W'(mode_reg);
            hbp_pkg::REG_HEIGHT:     prdata = hbp_pkg::DATA_W'(height_reg);
            hbp_pkg::REG_FULL_SCALE: prdata = full_scale_reg;
            default:                 prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_column    = column_reg;
    assign m_pixels    = pixels_reg;
    assign m_frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PW_CNT)
        else $error("sample count above plot width");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_rsp.done |-> (state_reg == ST_COL_DIV))
        else $error("level result outside divider wait");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan of empty history");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_COL_OUT) && m_free && (idx_reg == LAST_IDX))
        |=> ((count_reg == '0) && (wp_reg == '0) && (state_reg == ST_IDLE)))
        else $error("history not restarted after frame");
`endif

endmodule

@@ tb/hbp_frame_checker.sv @@
`timescale 1ns / 1ps

module hbp_frame_checker #(
    parameter int PLOT_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [hbp_pkg::VAL_W-1:0]    s_sample,
    input  logic                         s_last,

    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [hbp_pkg::COLUMN_W-1:0] m_column,
    input  logic [hbp_pkg::PIXELS_W-1:0] m_pixels,
    input  logic                         m_frame_end,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [hbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [hbp_pkg::DATA_W-1:0]   pwdata,

    output int                           mismatch_count,
    output int                           columns_pending
);

    typedef struct packed {
        logic [hbp_pkg::COLUMN_W-1:0] column;
        logic [hbp_pkg::PIXELS_W-1:0] pixels;
        logic                         frame_end;
    } bar_column_t;

    bar_column_t                  expected_columns[$];

    logic [hbp_pkg::VAL_W-1:0]    history[PLOT_WIDTH];
    logic [5:0]                   history_count;
    logic [hbp_pkg::COLUMN_W-1:0] write_slot;

    logic [hbp_pkg::MODE_W-1:0]   mode_reg;
    logic [hbp_pkg::HEIGHT_W-1:0] height_reg;
    logic [hbp_pkg::VAL_W-1:0]    full_scale_reg;

    function automatic int unsigned bar_level(logic [hbp_pkg::VAL_W-1:0] v,
                                              logic [hbp_pkg::VAL_W-1:0] div,
                                              int unsigned h);
        logic [63:0] lvl;
        if (div == 0)
            return 0;
        if (v > div)
            v = div;
        lvl = (64'(v) * 64'(h)) / 64'(div);
        if (lvl > 64'(h - 1))
            lvl = 64'(h - 1);
        return int'(lvl);
    endfunction

    // store one sample; on last, render the whole frame into expected_columns
    task automatic take_sample(input logic [hbp_pkg::VAL_W-1:0] value, input logic is_last);
        logic [hbp_pkg::VAL_W-1:0]    lo;
        logic [hbp_pkg::VAL_W-1:0]    hi;
        logic [hbp_pkg::VAL_W-1:0]    v;
        logic [hbp_pkg::VAL_W-1:0]    div;
        logic [hbp_pkg::COLUMN_W-1:0] slot;
        int unsigned                  h;
        int unsigned                  lvl;
        int                           age;
        bar_column_t                  col;

        history[write_slot] = value;
        write_slot = write_slot + 1'b1;
        if (history_count < PLOT_WIDTH)
            history_count = history_count + 1'b1;
        if (!is_last)
            return;

        h = 32'((height_reg > hbp_pkg::MAX_HEIGHT) ? hbp_pkg::MAX_HEIGHT : height_reg);
        lo = '1;
        hi = '0;
        for (age = 0; age < history_count; age++) begin
            slot = hbp_pkg::COLUMN_W'(write_slot - 1 - age);
            if (history[slot] < lo) lo = history[slot];
            if (history[slot] > hi) hi = history[slot];
        end

        for (int c = 0; c < PLOT_WIDTH; c++) begin
            col.column    = hbp_pkg::COLUMN_W'(c);
            col.pixels    = '0;
            col.frame_end = (c == PLOT_WIDTH - 1);
            age = PLOT_WIDTH - 1 - c;
            if (age < history_count && h > 0) begin
                slot = hbp_pkg::COLUMN_W'(write_slot - 1 - age);
                v = history[slot];
                if (mode_reg == hbp_pkg::MODE_RAW) begin
                    div = full_scale_reg;
                end else if (mode_reg == hbp_pkg::MODE_NORM) begin
                    div = hi;
                end else begin
                    div = hi - lo;
                    v = v - lo;
                end
                lvl = bar_level(v, div, h);
                col.pixels = 8'((9'd1 << (lvl + 1)) - 1);
            end
            expected_columns.push_back(col);
        end

        history_count = '0;
        write_slot = '0;
    endtask

    always @(posedge aclk) begin
        bar_column_t want;
        if (!aresetn) begin
            expected_columns.delete();
            history_count  = '0;
            write_slot     = '0;
            mode_reg       = hbp_pkg::RESET_MODE;
            height_reg     = hbp_pkg::RESET_HEIGHT;
            full_scale_reg = hbp_pkg::RESET_FULL_SCALE;
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_columns.size() == 0) begin
                    mismatch_count++;
                    $error("column %0d arrived with no frame pending", m_column);
                end else begin
                    want = expected_columns.pop_front();
                    if (m_column !== want.column) begin
                        mismatch_count++;
                        $error("column: expected %0d, got %0d", want.column, m_column);
                    end
                    if (m_pixels !== want.pixels) begin
                        mismatch_count++;
                        $error("pixels: expected 0x%02h, got 0x%02h", want.pixels, m_pixels);
                    end
                    if (m_frame_end !== want.frame_end) begin
                        mismatch_count++;
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, m_frame_end);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    hbp_pkg::REG_MODE:       mode_reg = pwdata[hbp_pkg::MODE_W-1:0];
                    hbp_pkg::REG_HEIGHT:     height_reg = pwdata[hbp_pkg::HEIGHT_W-1:0];
                    hbp_pkg::REG_FULL_SCALE: full_scale_reg = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                take_sample(s_sample, s_last);
        end
        columns_pending = expected_columns.size();
    end

endmodule

@@ tb/tb_history_bar_plot_renderer_top.sv @@
`timescale 1ns / 1ps

module tb_history_bar_plot_renderer_top;

    localparam logic [hbp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int RECEIVER_HOLD_CYCLES = 400;

    logic                         aclk;
    logic                         aresetn;

    logic                         s_valid;
    logic                         s_ready;
    logic [hbp_pkg::VAL_W-1:0]    s_sample;
    logic                         s_last;

    logic                         m_valid;
    logic                         m_ready;
    logic [hbp_pkg::COLUMN_W-1:0] m_column;
    logic [hbp_pkg::PIXELS_W-1:0] m_pixels;
    logic                         m_frame_end;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [hbp_pkg::ADDR_W-1:0]   paddr;
    logic [hbp_pkg::DATA_W-1:0]   pwdata;
    logic [hbp_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int                           mismatch_count;
    int                           columns_pending;

    bit                           no_gaps;
    bit                           hold_request;

    history_bar_plot_renderer_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_column    (m_column),
        .m_pixels    (m_pixels),
        .m_frame_end (m_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    hbp_frame_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_column        (m_column),
        .m_pixels        (m_pixels),
        .m_frame_end     (m_frame_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .columns_pending (columns_pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                m_ready = 1'b0;
                repeat (RECEIVER_HOLD_CYCLES) @(negedge aclk);
                hold_served = 1'b1;
            end
            m_ready = no_gaps || ($urandom_range(99) >= 28);
        end
    end

    task automatic push_sample(input logic [hbp_pkg::VAL_W-1:0] value, input logic is_last);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 28) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = value;
        s_last   = is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, then hold until every column of the frame has come out
    task automatic drain_columns();
        @(negedge aclk);
        s_valid = 1'b0;
        while (columns_pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index,
                                  input logic [hbp_pkg::DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_plot(input logic [hbp_pkg::MODE_W-1:0] mode,
                            input logic [hbp_pkg::HEIGHT_W-1:0] height,
                            input logic [hbp_pkg::VAL_W-1:0] full_scale);
        drain_columns();
        write_register(hbp_pkg::REG_MODE, hbp_pkg::DATA_W'(mode));
        write_register(hbp_pkg::REG_HEIGHT, hbp_pkg::DATA_W'(height));
        write_register(hbp_pkg::REG_FULL_SCALE, full_scale);
    endtask

    initial begin
        int                           random_items;
        int                           frame_no;
        int                           frame_len;
        int                           style;
        logic [hbp_pkg::VAL_W-1:0]    base;
        logic [hbp_pkg::VAL_W-1:0]    value;
        logic [hbp_pkg::VAL_W-1:0]    full_scale;
        logic [hbp_pkg::HEIGHT_W-1:0] height;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample     = '0;
        s_last       = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: norm mode, extremes of the sample range
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        // all-zero window: zero divisor
        push_sample(32'h0000_0000, 1'b1);

        // raw mode with saturation above full scale
        set_plot(hbp_pkg::MODE_RAW, 4'd8, 32'd1000);
        push_sample(32'd0, 1'b0);
        push_sample(32'd999, 1'b0);
        push_sample(32'd1000, 1'b0);
        push_sample(32'd5000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);

        // flat window in fluct mode: zero divisor
        set_plot(hbp_pkg::MODE_FLUCT, 4'd1, 32'd1000);
        push_sample(32'd7, 1'b0);
        push_sample(32'd7, 1'b0);
        push_sample(32'd7, 1'b1);

        // spare mode code and a height above eight
        set_plot(MODE_SPARE, 4'd12, 32'd1000);
        push_sample(32'd10, 1'b0);
        push_sample(32'd20, 1'b0);
        push_sample(32'd30, 1'b0);
        push_sample(32'd40, 1'b1);

        // zero height: blank frame
        set_plot(hbp_pkg::MODE_NORM, 4'd0, 32'd1000);
        push_sample(32'd5, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);

        set_plot(hbp_pkg::MODE_RAW, 4'd8, 32'hFFFF_FFFF);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b1);

        set_plot(hbp_pkg::MODE_RAW, 4'd7, 32'd1);
        push_sample(32'd0, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b1);

        random_items = 0;
        frame_no = 0;
        while (random_items < 350) begin
            if (frame_no % 4 == 0) begin
                case ($urandom_range(3))
                    0:       full_scale = $urandom_range(1, 255);
                    1:       full_scale = $urandom;
                    2:       full_scale = 32'hFFFF_FFFF;
                    default: full_scale = $urandom_range(1, 65535);
                endcase
                if (full_scale == 0)
                    full_scale = 1;
                height = hbp_pkg::HEIGHT_W'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                                     : $urandom_range(1, 8));
                set_plot(hbp_pkg::MODE_W'($urandom_range(3)), height, full_scale);
            end
            // hold the result side so the rendered frame backs up into the input
            if (frame_no == 2)
                hold_request = 1'b1;
            no_gaps = (frame_no >= 8 && frame_no < 11);

            frame_len = ($urandom_range(9) == 0) ? $urandom_range(33, 48)
                                                 : $urandom_range(1, 32);
            style = $urandom_range(3);
            base = $urandom;
            for (int i = 0; i < frame_len; i++) begin
                case (style)
                    0:       value = $urandom;
                    1:       value = $urandom_range(255);
                    2:       value = base + $urandom_range(15);
                    default: begin
                        case ($urandom_range(3))
                            0:       value = 32'h0000_0000;
                            1:       value = 32'hFFFF_FFFF;
                            default: value = $urandom;
                        endcase
                    end
                endcase
                push_sample(value, i == frame_len - 1);
                random_items++;
            end
            frame_no++;
        end
        no_gaps = 1'b0;

        drain_columns();
        repeat (50) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
